>>> rtl/ulp_pkg.sv
// shared types and constants for the unique integer list parser
// no dependencies; used by ulp_cell, ulp_row and unique_integer_list_parser
`default_nettype none

package ulp_pkg;

	localparam int MAX_VALUES_DEF = 512;

	// mode codes of an input word
	localparam logic [1:0] MODE_CHAR     = 2'd0;
	localparam logic [1:0] MODE_ARG_END  = 2'd1;
	localparam logic [1:0] MODE_LIST_END = 2'd2;

	// character codes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	// magnitude limits, one bit wider than needed for the times-ten sum
	localparam logic [35:0] POS_LIMIT = 36'h07FFFFFFF;
	localparam logic [35:0] NEG_LIMIT = 36'h080000000;

	typedef enum logic [1:0] {
		KIND_VALUE = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] char_byte;
	} item_t;

	typedef struct packed {
		kind_t              kind;
		logic signed [31:0] value;
		logic [8:0]         index;
		logic [9:0]         total;
	} result_t;

	typedef struct packed {
		logic shift;
		logic write;
	} row_ctl_t;

endpackage

`default_nettype wire

>>> rtl/ulp_cell.sv
// one entry of the stored value ring
// uses ulp_pkg; instantiated by ulp_row
`default_nettype none

module ulp_cell
	import ulp_pkg::*;
#(
	parameter int CW  = 10,
	parameter int POS = 0
) (
	input  wire logic          clk,
	input  wire row_ctl_t      ctl,
	input  wire logic [CW-1:0] count,
	input  wire logic [31:0]   key,
	input  wire logic [31:0]   head,
	input  wire logic [31:0]   next_val,
	output logic [31:0]        value
);

	logic tail;
	logic here;

	// last filled entry closes the ring by taking the head value
	assign tail = (count == CW'(POS + 1));
	assign here = (count == CW'(POS));

	always_ff @(posedge clk) begin
		if (ctl.write && here) begin
			value <= key;
		end else if (ctl.shift) begin
			value <= tail ? head : next_val;
		end
	end

endmodule

`default_nettype wire

>>> rtl/ulp_row.sv
// row of value cells forming a rotating ring of the stored values
// uses ulp_pkg and ulp_cell; instantiated by unique_integer_list_parser
`default_nettype none

module ulp_row
	import ulp_pkg::*;
#(
	parameter int MAX_VALUES = MAX_VALUES_DEF
) (
	input  wire logic                              clk,
	input  wire row_ctl_t                          ctl,
	input  wire logic [$clog2(MAX_VALUES+1)-1:0]   count,
	input  wire logic [31:0]                       key,
	output logic [31:0]                            head
);

	localparam int CW = $clog2(MAX_VALUES + 1);

	logic [31:0] vals [MAX_VALUES];
	logic [31:0] nxt  [MAX_VALUES];

	assign head = vals[0];

	for (genvar i = 0; i < MAX_VALUES; i++) begin : g_cell
		if (i == MAX_VALUES - 1) begin : g_end
			assign nxt[i] = vals[0];
		end else begin : g_mid
			assign nxt[i] = vals[i+1];
		end

		ulp_cell #(
			.CW  (CW),
			.POS (i)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.count    (count),
			.key      (key),
			.head     (vals[0]),
			.next_val (nxt[i]),
			.value    (vals[i])
		);
	end

endmodule

`default_nettype wire

>>> rtl/unique_integer_list_parser.sv
// top level: character parser, control sequencer and two-word result queue
// uses ulp_pkg and ulp_row
//
// channel   | valid        | stall        | payload
// ----------+--------------+--------------+-----------------------------
// input     | item_valid   | item_stall   | item   (mode, char_byte)
// output    | result_valid | result_stall | result (kind, value, index, total)
//
// a character that ends no token is accepted in idle; each result word passes the emit state
// a token end walks the ring of stored values past the head comparator, one
// entry per cycle, until the key matches the head or every stored value has passed
// reset clears the parser state and the fill count; the value ring needs no clearing
// item_stall is high whenever the sequencer is busy; results wait in a two-word
// queue, so the sequencer only halts on result_stall once that queue is full
`default_nettype none

module unique_integer_list_parser
	import ulp_pkg::*;
#(
	parameter int MAX_VALUES = MAX_VALUES_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_stall,
	input  wire item_t   item,
	output logic         result_valid,
	input  wire logic    result_stall,
	output result_t      result
);

	localparam int CW = $clog2(MAX_VALUES + 1);

	state_t         state_q, state_d;
	logic           in_token_q, in_token_d;
	logic           negative_q, negative_d;
	logic           digit_seen_q, digit_seen_d;
	logic [31:0]    mag_q, mag_d;
	logic           arg_chars_q, arg_chars_d;
	logic           arg_token_q, arg_token_d;
	logic           error_q, error_d;
	logic [CW-1:0]  count_q, count_d;
	logic [CW-1:0]  scan_q, scan_d;
	logic [1:0]     ctx_q, ctx_d;
	logic [31:0]    key_q, key_d;
	result_t        pa_q, pa_d;
	result_t        pb_q, pb_d;
	logic           pb_v_q, pb_v_d;

	// result queue
	logic           v0_q, v1_q;
	result_t        d0_q, d1_q;
	logic           push;
	logic           pop;
	logic           full;

	logic           start_tok;
	logic           raise;
	logic           clr_tok;
	logic           clr_arg;
	logic           clr_all;

	logic [7:0]     c;
	logic           blank;
	logic           is_sign;
	logic           is_digit;
	logic [35:0]    acc;
	logic           ovf;
	logic [31:0]    word;
	logic [CW-1:0]  count_inc;
	logic [CW+9:0]  count_ext;
	logic [CW+9:0]  inc_ext;
	result_t        err_res;
	result_t        val_res;
	result_t        done_res;

	row_ctl_t       ctl;
	logic [31:0]    head;

	ulp_row #(
		.MAX_VALUES (MAX_VALUES)
	) u_row (
		.clk   (clk),
		.ctl   (ctl),
		.count (count_q),
		.key   (key_q),
		.head  (head)
	);

	assign c        = item.char_byte;
	assign blank    = (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
	assign is_sign  = (c == CH_PLUS) || (c == CH_MINUS);
	assign is_digit = c inside {[CH_ZERO:CH_NINE]};

	// magnitude * 10 + digit as shift-and-add
	assign acc = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1) + {32'b0, c[3:0]};
	assign ovf = acc > (negative_q ? NEG_LIMIT : POS_LIMIT);
	assign word = negative_q ? (32'd0 - mag_q) : mag_q;

	assign count_inc = count_q + CW'(1);
	assign count_ext = {10'b0, count_q};
	assign inc_ext   = {10'b0, count_inc};

	always_comb begin
		err_res       = '0;
		err_res.kind  = KIND_ERROR;
		err_res.total = count_ext[9:0];

		done_res       = '0;
		done_res.kind  = (count_q != '0) ? KIND_DONE : KIND_ERROR;
		done_res.total = count_ext[9:0];

		val_res.kind  = KIND_VALUE;
		val_res.value = $signed(key_q);
		val_res.index = count_ext[8:0];
		val_res.total = inc_ext[9:0];
	end

	assign item_stall = (state_q != ST_IDLE);
	assign full       = v0_q & v1_q;
	assign pop        = v0_q & ~result_stall;

	always_comb begin
		state_d      = state_q;
		in_token_d   = in_token_q;
		negative_d   = negative_q;
		digit_seen_d = digit_seen_q;
		mag_d        = mag_q;
		arg_chars_d  = arg_chars_q;
		arg_token_d  = arg_token_q;
		error_d      = error_q;
		count_d      = count_q;
		scan_d       = scan_q;
		ctx_d        = ctx_q;
		key_d        = key_q;
		pa_d         = pa_q;
		pb_d         = pb_q;
		pb_v_d       = pb_v_q;
		push         = 1'b0;
		ctl          = '0;
		start_tok    = 1'b0;
		raise        = 1'b0;
		clr_tok      = 1'b0;
		clr_arg      = 1'b0;
		clr_all      = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					case (item.mode)
						MODE_CHAR: begin
							if (!error_q) begin
								arg_chars_d = 1'b1;
								if (blank) begin
									start_tok = in_token_q;
								end else if (!in_token_q && is_sign) begin
									in_token_d = 1'b1;
									negative_d = (c == CH_MINUS);
								end else if (is_digit) begin
									in_token_d = 1'b1;
									if (ovf) begin
										raise = 1'b1;
									end else begin
										mag_d        = acc[31:0];
										digit_seen_d = 1'b1;
									end
								end else begin
									raise = 1'b1;
								end
							end
						end
						MODE_ARG_END: begin
							if (!error_q) begin
								if (in_token_q) begin
									start_tok = 1'b1;
								end else begin
									raise   = ~arg_token_q;
									clr_arg = 1'b1;
								end
							end
						end
						MODE_LIST_END: begin
							if (error_q) begin
								clr_all = 1'b1;
							end else if (in_token_q) begin
								start_tok = 1'b1;
							end else if (arg_chars_q && !arg_token_q) begin
								// blank-only argument still open
								raise   = 1'b1;
								clr_all = 1'b1;
							end else begin
								pa_d    = done_res;
								state_d = ST_EMIT;
								clr_all = 1'b1;
							end
						end
						default: begin
						end
					endcase

					if (start_tok) begin
						ctx_d = item.mode;
						if (!digit_seen_q || count_q == CW'(MAX_VALUES)) begin
							// bare sign or full table
							raise = 1'b1;
							if (item.mode == MODE_ARG_END) begin
								clr_arg = 1'b1;
							end
							if (item.mode == MODE_LIST_END) begin
								clr_all = 1'b1;
							end
						end else begin
							key_d   = word;
							scan_d  = '0;
							state_d = ST_SCAN;
						end
					end

					if (raise) begin
						pa_d    = err_res;
						state_d = ST_EMIT;
						error_d = ~clr_all;
					end
				end
			end
			ST_SCAN: begin
				if (scan_q == count_q) begin
					// no match among the stored values: append
					ctl.write   = 1'b1;
					count_d     = count_inc;
					pa_d        = val_res;
					arg_token_d = 1'b1;
					clr_tok     = 1'b1;
					state_d     = ST_EMIT;
					if (ctx_q == MODE_ARG_END) begin
						clr_arg = 1'b1;
					end
					if (ctx_q == MODE_LIST_END) begin
						clr_all       = 1'b1;
						pb_d          = '0;
						pb_d.kind     = KIND_DONE;
						pb_d.total    = inc_ext[9:0];
						pb_v_d        = 1'b1;
					end
				end else if (head == key_q) begin
					pa_d    = err_res;
					state_d = ST_EMIT;
					if (ctx_q == MODE_LIST_END) begin
						clr_all = 1'b1;
					end else begin
						error_d = 1'b1;
						clr_arg = (ctx_q == MODE_ARG_END);
					end
				end else begin
					ctl.shift = 1'b1;
					scan_d    = scan_q + CW'(1);
				end
			end
			ST_EMIT: begin
				if (!full) begin
					push = 1'b1;
					if (pb_v_q) begin
						pa_d   = pb_q;
						pb_v_d = 1'b0;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (clr_tok || clr_arg || clr_all) begin
			in_token_d   = 1'b0;
			negative_d   = 1'b0;
			digit_seen_d = 1'b0;
			mag_d        = '0;
		end
		if (clr_arg || clr_all) begin
			arg_chars_d = 1'b0;
			arg_token_d = 1'b0;
		end
		if (clr_all) begin
			error_d = 1'b0;
			count_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			in_token_q   <= 1'b0;
			negative_q   <= 1'b0;
			digit_seen_q <= 1'b0;
			mag_q        <= '0;
			arg_chars_q  <= 1'b0;
			arg_token_q  <= 1'b0;
			error_q      <= 1'b0;
			count_q      <= '0;
			scan_q       <= '0;
			ctx_q        <= MODE_CHAR;
			pb_v_q       <= 1'b0;
			v0_q         <= 1'b0;
			v1_q         <= 1'b0;
		end else begin
			state_q      <= state_d;
			in_token_q   <= in_token_d;
			negative_q   <= negative_d;
			digit_seen_q <= digit_seen_d;
			mag_q        <= mag_d;
			arg_chars_q  <= arg_chars_d;
			arg_token_q  <= arg_token_d;
			error_q      <= error_d;
			count_q      <= count_d;
			scan_q       <= scan_d;
			ctx_q        <= ctx_d;
			pb_v_q       <= pb_v_d;
			if (pop) begin
				v0_q <= v1_q | push;
				v1_q <= v1_q & push;
			end else if (push) begin
				if (!v0_q) begin
					v0_q <= 1'b1;
				end else begin
					v1_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_d;
		pa_q  <= pa_d;
		pb_q  <= pb_d;
		if (pop) begin
			d0_q <= v1_q ? d1_q : pa_q;
		end else if (push && !v0_q) begin
			d0_q <= pa_q;
		end
		if (push && v0_q && !pop) begin
			d1_q <= pa_q;
		end
	end

	assign result_valid = v0_q;
	assign result       = d0_q;

endmodule

`default_nettype wire

>>> sim/testbench.sv
// testbench for unique_integer_list_parser: directed table, a table fill and random lists
// expected words come from the parser model or fixed rows, compared field by field
// depends on ulp_pkg and the rtl top level only

module testbench;
	import ulp_pkg::*;

	localparam int MAX_VALUES = MAX_VALUES_DEF;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int WORDS_PER_PHASE = 120;
	localparam int DRAIN_CYCLES = 600;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam result_t NO_RESULT = '{KIND_VALUE, 32'sd0, 9'd0, 10'd0};
	localparam result_t ERR_EMPTY = '{KIND_ERROR, 32'sd0, 9'd0, 10'd0};

	typedef struct packed {
		item_t   word;
		logic    fixed;
		logic    has_result;
		result_t result;
	} stim_row_t;

	// fixed rows carry the result typed in (or none); the others go to the predictor
	localparam stim_row_t DIRECTED_ROWS [27] = '{
		'{'{MODE_LIST_END, 8'h00}, 1'b1, 1'b1, ERR_EMPTY},
		'{'{MODE_UNUSED, 8'hFF}, 1'b1, 1'b0, NO_RESULT},
		'{'{MODE_CHAR, "-"}, 1'b0, 1'b0, NO_RESULT},
		'{'{MODE_CHAR, "7"}, 1'b0, 1'b0, NO_RESULT},
		'{'{MODE_CHAR, " "}, 1'b1, 1'b1, '{KIND_VALUE, -32'sd7, 9'd0, 10'd1}},
		'{'{MODE_CHAR, "7"}, 1'b0, 1'b0, NO_RESULT},
		'{'{MODE_ARG_END, 8'h00}, 1'b1, 1'b1, '{KIND_VALUE, 32'sd7, 9'd1, 10'd2}},
		'{'{MODE_CHAR, "+"}, 1'b0, 1'b0, NO_RESULT},
		'{'{MODE_CHAR, "7"}, 1'b0, 1'b0, NO_RESULT},
		'{'{MODE_CHAR, 8'h09}, 1'b1, 1'b1, '{KIND_ERROR, 32'sd0, 9'd0, 10'd2}},
		'{'{MODE_CHAR, "5"}, 1'b1, 1'b0, NO_RESULT},
		'{'{MODE_LIST_END, 8'h00}, 1'b1, 1'b0, NO_RESULT},
		'{'{MODE_ARG_END, 8'hFF}, 1'b1, 1'b1, ERR_EMPTY},
		'{'{MODE_LIST_END, 8'h00}, 1'b1, 1'b0, NO_RESULT},
		'{'{MODE_CHAR, " "}, 1'b0, 1'b0, NO_RESULT},
		'{'{MODE_ARG_END, 8'h00}, 1'b1, 1'b1, ERR_EMPTY},
		'{'{MODE_LIST_END, 8'h00}, 1'b1, 1'b0, NO_RESULT},
		'{'{MODE_CHAR, "-"}, 1'b0, 1'b0, NO_RESULT},
		'{'{MODE_CHAR, " "}, 1'b1, 1'b1, ERR_EMPTY},
		'{'{MODE_LIST_END, 8'h00}, 1'b1, 1'b0, NO_RESULT},
		'{'{MODE_CHAR, 8'h00}, 1'b1, 1'b1, ERR_EMPTY},
		'{'{MODE_LIST_END, 8'hFF}, 1'b1, 1'b0, NO_RESULT},
		'{'{MODE_CHAR, "1"}, 1'b0, 1'b0, NO_RESULT},
		'{'{MODE_LIST_END, 8'h00}, 1'b0, 1'b0, NO_RESULT},
		'{'{MODE_CHAR, "+"}, 1'b0, 1'b0, NO_RESULT},
		'{'{MODE_CHAR, "-"}, 1'b1, 1'b1, ERR_EMPTY},
		'{'{MODE_LIST_END, 8'h00}, 1'b1, 1'b0, NO_RESULT}
	};

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	int send_gap_pct = 0;
	int stall_pct = 0;
	int live_words = 0;
	int mismatch_count = 0;
	int cycle_count = 0;

	// parser model state
	logic        tok_open = 1'b0;
	logic        tok_neg = 1'b0;
	logic        tok_digits = 1'b0;
	logic [31:0] tok_mag = '0;
	logic        arg_chars = 1'b0;
	logic        arg_token = 1'b0;
	logic        err_latched = 1'b0;
	int          stored_count = 0;
	logic [31:0] stored_values [MAX_VALUES];
	result_t     awaited_results [$];

	unique_integer_list_parser dut (
		.clk,
		.arst_n,
		.item_valid,
		.item_stall,
		.item,
		.result_valid,
		.result_stall,
		.result
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic void push_result(kind_t k, logic [31:0] v, int idx);
		awaited_results.push_back('{kind: k, value: v, index: 9'(idx),
			total: 10'(stored_count)});
	endfunction

	function automatic void flag_error();
		err_latched = 1'b1;
		push_result(KIND_ERROR, '0, 0);
	endfunction

	function automatic void drop_token();
		tok_open = 1'b0;
		tok_neg = 1'b0;
		tok_digits = 1'b0;
		tok_mag = '0;
	endfunction

	function automatic void clear_arg();
		drop_token();
		arg_chars = 1'b0;
		arg_token = 1'b0;
	endfunction

	function automatic void close_token();
		logic [31:0] v;
		if (!tok_digits) begin
			flag_error();
			return;
		end
		v = tok_neg ? -tok_mag : tok_mag;
		for (int i = 0; i < stored_count; i++) begin
			if (stored_values[i] == v) begin
				flag_error();
				return;
			end
		end
		if (stored_count >= MAX_VALUES) begin
			flag_error();
			return;
		end
		stored_values[stored_count] = v;
		stored_count++;
		arg_token = 1'b1;
		drop_token();
		push_result(KIND_VALUE, v, stored_count - 1);
	endfunction

	function automatic void take_char(logic [7:0] c);
		logic [35:0] grown;
		arg_chars = 1'b1;
		if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
			if (tok_open)
				close_token();
			return;
		end
		// a sign only counts as the first character of a token
		if (!tok_open) begin
			tok_open = 1'b1;
			if (c == CH_PLUS || c == CH_MINUS) begin
				tok_neg = (c == CH_MINUS);
				return;
			end
		end
		if (c >= CH_ZERO && c <= CH_NINE) begin
			grown = {4'd0, tok_mag} * 36'd10 + 36'(c - CH_ZERO);
			if (grown > (tok_neg ? NEG_LIMIT : POS_LIMIT)) begin
				flag_error();
				return;
			end
			tok_mag = grown[31:0];
			tok_digits = 1'b1;
			return;
		end
		flag_error();
	endfunction

	function automatic void close_arg();
		if (tok_open)
			close_token();
		if (!err_latched && !arg_token)
			flag_error();
		clear_arg();
	endfunction

	// returns the number of result words this input word causes
	function automatic int parse_word(item_t w);
		int queued;
		queued = awaited_results.size();
		case (w.mode)
			MODE_CHAR: begin
				if (!err_latched)
					take_char(w.char_byte);
			end
			MODE_ARG_END: begin
				if (!err_latched)
					close_arg();
			end
			MODE_LIST_END: begin
				if (!err_latched && (arg_chars || tok_open))
					close_arg();
				if (!err_latched)
					push_result(stored_count > 0 ? KIND_DONE : KIND_ERROR, '0, 0);
				clear_arg();
				err_latched = 1'b0;
				stored_count = 0;
			end
			default: ;
		endcase
		return awaited_results.size() - queued;
	endfunction

	function automatic void note_mismatch(string what, result_t want, result_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%s: expected kind %0d value %0d index %0d total %0d", what,
				want.kind, want.value, want.index, want.total);
			$display("%s: got kind %0d value %0d index %0d total %0d", what,
				got.kind, got.value, got.index, got.total);
		end
	endfunction

	task automatic send_word(input item_t w, output int produced);
		while ($urandom_range(99) < send_gap_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= w;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		// words dropped while an error is pending do not count as live stimulus
		if (w.mode != MODE_UNUSED && (!err_latched || w.mode == MODE_LIST_END))
			live_words++;
		produced = parse_word(w);
	endtask

	task automatic send_mode(input logic [1:0] m, input logic [7:0] c);
		int unused_n;
		send_word('{mode: m, char_byte: c}, unused_n);
	endtask

	task automatic send_blank();
		send_mode(MODE_CHAR, $urandom_range(1) ? CH_SPACE : CH_TAB + 8'($urandom_range(4)));
	endtask

	task automatic send_noise();
		case ($urandom_range(2))
			0: send_mode(MODE_CHAR, 8'($urandom));
			1: send_mode(MODE_UNUSED, 8'($urandom));
			default: send_mode(MODE_CHAR, $urandom_range(1) ? CH_PLUS : CH_MINUS);
		endcase
	endtask

	task automatic send_number(input bit neg, input bit show_plus, input longint unsigned mag);
		logic [7:0] digits [$];
		if (neg)
			send_mode(MODE_CHAR, CH_MINUS);
		else if (show_plus)
			send_mode(MODE_CHAR, CH_PLUS);
		do begin
			digits.push_front(CH_ZERO + 8'(mag % 10));
			mag = mag / 10;
		end while (mag != 0);
		if ($urandom_range(9) == 0)
			repeat ($urandom_range(1, 3)) digits.push_front(CH_ZERO);
		foreach (digits[i])
			send_mode(MODE_CHAR, digits[i]);
	endtask

	task automatic send_token();
		int     pick;
		longint v;
		bit     neg;
		pick = $urandom_range(99);
		if (pick < 3) begin
			send_mode(MODE_CHAR, $urandom_range(1) ? CH_PLUS : CH_MINUS);
			return;
		end
		if (pick < 60)
			v = longint'($urandom_range(400)) - 200;
		else if (pick < 83)
			v = longint'(signed'($urandom));
		else if (pick < 96) begin
			case ($urandom_range(5))
				0: v = 64'sd2147483647;
				1: v = -64'sd2147483648;
				2: v = 64'sd2147483648;
				3: v = -64'sd2147483649;
				4: v = 64'sd0;
				default: v = 64'sd4294967295;
			endcase
		end else
			v = longint'({$urandom, $urandom} % 64'd99999999999);
		neg = v < 0 || (v == 0 && $urandom_range(3) == 0);
		send_number(neg, $urandom_range(3) == 0, v < 0 ? -v : v);
	endtask

	task automatic send_random_list();
		int args;
		int toks;
		args = $urandom_range(1, 4);
		for (int a = 0; a < args; a++) begin
			if ($urandom_range(99) < 5) begin
				repeat ($urandom_range(2)) send_blank();
			end else begin
				if ($urandom_range(3) == 0)
					send_blank();
				toks = $urandom_range(1, 4);
				for (int t = 0; t < toks; t++) begin
					if (t > 0)
						repeat ($urandom_range(1, 2)) send_blank();
					send_token();
					if ($urandom_range(99) < 4)
						send_noise();
				end
				if ($urandom_range(2) == 0)
					send_blank();
			end
			// the last argument may be left open for the end of list to close
			if (a < args - 1 || $urandom_range(2) != 0)
				send_mode(MODE_ARG_END, 8'($urandom));
		end
		send_mode(MODE_LIST_END, 8'($urandom));
	endtask

	// stores short distinct values in every table slot, then one more to hit the full table
	task automatic fill_table();
		for (int i = 0; i <= MAX_VALUES; i++) begin
			send_number(1'b0, 1'b0, 64'(i));
			if (i % 64 == 63)
				send_mode(MODE_ARG_END, 8'($urandom));
			else
				send_blank();
		end
		send_mode(MODE_LIST_END, 8'($urandom));
	endtask

	always @(posedge clk) begin : watch_results
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (awaited_results.size() == 0)
				note_mismatch("result word with none awaited", NO_RESULT, result);
			else begin
				want = awaited_results.pop_front();
				if (result.kind !== want.kind || result.value !== want.value ||
						result.index !== want.index || result.total !== want.total)
					note_mismatch("result word differs", want, result);
			end
		end
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin : stimulus
		stim_row_t row;
		int        produced;
		int        phase_goal;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		send_gap_pct = 14;
		stall_pct = 49;
		foreach (DIRECTED_ROWS[i]) begin
			row = DIRECTED_ROWS[i];
			send_word(row.word, produced);
			if (row.fixed) begin
				repeat (produced) void'(awaited_results.pop_back());
				if (row.has_result)
					awaited_results.push_back(row.result);
			end
		end
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_gap_pct = 14;
					stall_pct = 49;
				end
				1: begin
					send_gap_pct = 49;
					stall_pct = 14;
				end
				default: begin
					send_gap_pct = 0;
					stall_pct = 0;
					fill_table();
				end
			endcase
			phase_goal = live_words + WORDS_PER_PHASE;
			while (live_words < phase_goal)
				send_random_list();
			// hold the input until the parser has answered everything
			item_valid <= 1'b0;
			do @(posedge clk); while (awaited_results.size() != 0);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> filelist.f
rtl/ulp_pkg.sv
rtl/ulp_cell.sv
rtl/ulp_row.sv
rtl/unique_integer_list_parser.sv
sim/testbench.sv
